// ===== rtl/signal_meter_peak_hold_unit_assert.svh =====
// assertion macros shared by the level meter rtl
`ifndef SIGNAL_METER_PEAK_HOLD_UNIT_ASSERT_SVH
`define SIGNAL_METER_PEAK_HOLD_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SHM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SHM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/shm_pkg.sv =====
// shared types and constants of the peak-hold level meter
package shm_pkg;

  // field widths
  localparam int BIN_W      = 13;
  localparam int LEVEL_W    = 12;
  localparam int HDB_W      = 9;
  localparam int SU_W       = 4;
  localparam int HOLD_W     = 16;
  localparam int DECAY_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_W      = 30;

  // default averaging depth in frames
  localparam int AVG_DEPTH_DEF = 5;

  typedef logic signed [BIN_W-1:0] db_t;
  typedef logic [LEVEL_W-1:0]      level_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_FRAMES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP  = 2'd1;

  // register reset values
  localparam logic [HOLD_W-1:0]  HOLD_RST  = 16'd240;
  localparam logic [DECAY_W-1:0] DECAY_RST = 8'd5;

  // levels and limits
  localparam db_t    PEAK_MIN  = 13'sh1000;
  localparam db_t    DB_FLOOR  = -13'sd2024;
  localparam level_t LEVEL_MAX = 12'd3840;
  localparam level_t LEVEL_S9  = 12'd2304;
  localparam logic [SU_W-1:0] SU_MAX = 4'd10;

  // fixed-point coefficients of the dB to level map and its inverse
  localparam logic signed [31:0] LVL_GAIN = 32'sd162529;
  localparam logic signed [31:0] LVL_OFS  = 32'sd332474089;
  localparam logic [22:0]        HDB_GAIN = 23'd1658;
  localparam logic signed [24:0] HDB_OFS  = 25'sd8413577;
  localparam logic [27:0]        SU_GAIN  = 28'd65784;
  localparam logic signed [28:0] SU_OFS   = 29'sd1376655;

  // live configuration
  typedef struct packed {
    logic [HOLD_W-1:0]  hold_frames;
    logic [DECAY_W-1:0] decay_step;
  } shm_cfg_t;

  // instant and held level of one frame
  typedef struct packed {
    level_t now;
    level_t held;
  } shm_lvl_t;

  // one result, first field in the highest bits
  typedef struct packed {
    logic                    over_s9;
    logic [SU_W-1:0]         s_unit;
    logic signed [HDB_W-1:0] held_db;
    level_t                  level_held;
    level_t                  level_now;
  } shm_res_t;

endpackage

// ===== rtl/shm_avg.sv =====
// frame peak tracking, moving average over frames and clamped average dB
`include "signal_meter_peak_hold_unit_assert.svh"

module shm_avg #(
  parameter int AVG_DEPTH = shm_pkg::AVG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  shm_pkg::db_t in_bin,
  input  logic        in_bin_valid,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output shm_pkg::db_t out_db
);
  import shm_pkg::*;

  // running sum is kept with every entry offset by half range, so it stays unsigned
  localparam int U_W = BIN_W + $clog2(AVG_DEPTH + 1);
  localparam int L_W = $clog2(AVG_DEPTH);
  localparam int SH  = U_W + L_W;
  localparam int M_W = U_W + 1;
  localparam int P_W = U_W + M_W;
  localparam longint unsigned RECIP = ((64'd1 << SH) + AVG_DEPTH - 1) / AVG_DEPTH;
  localparam logic [BIN_W-1:0] HIST_RST = {1'b1, {(BIN_W-1){1'b0}}};
  localparam logic [U_W-1:0]   U_RST    = U_W'(AVG_DEPTH << (BIN_W - 1));

  // input stage
  logic       v0_r;
  db_t        bin0_r;
  logic       bv0_r;
  logic       last0_r;

  // frame state
  db_t        peak_r;
  logic       any_r;
  logic [BIN_W-1:0] hist_r [AVG_DEPTH];
  logic [U_W-1:0]   u_r;

  // average pipeline
  logic           v1_r, v2_r, v3_r;
  logic           empty1_r, empty2_r;
  logic [U_W-1:0] u1_r;
  logic [P_W-1:0] prod2_r;
  db_t            db3_r;

  logic rdy1, rdy2, rdy3, mv0, close, push, hit, any_upd;
  db_t  peak_upd;
  logic [BIN_W-1:0] peak_off, quo;
  logic [U_W-1:0]   u_nxt;
  db_t  dq, db_c;

  // stall chain, only closing transactions go past the input stage
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign mv0      = v0_r && (!last0_r || rdy1);
  assign in_ready = !v0_r || mv0;

  // peak of the frame including the bin in the input stage
  assign hit      = bv0_r && (!any_r || (bin0_r > peak_r));
  assign peak_upd = hit ? bin0_r : peak_r;
  assign any_upd  = any_r || bv0_r;
  assign close    = mv0 && last0_r;
  assign push     = close && any_upd;

  // running sum swaps the oldest entry for the new peak
  assign peak_off = {~peak_upd[BIN_W-1], peak_upd[BIN_W-2:0]};
  assign u_nxt    = u_r + U_W'(peak_off) - U_W'(hist_r[AVG_DEPTH-1]);

  // floor division by reciprocal, then back to signed dB and clamp; a frame with no valid bin gives 0
  assign quo  = prod2_r[SH +: BIN_W];
  assign dq   = {~quo[BIN_W-1], quo[BIN_W-2:0]};
  assign db_c = empty2_r ? db_t'(0) : ((dq < DB_FLOOR) ? DB_FLOOR : dq);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r   <= 1'b0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      peak_r <= PEAK_MIN;
      any_r  <= 1'b0;
      u_r    <= U_RST;
      for (int i = 0; i < AVG_DEPTH; i++) hist_r[i] <= HIST_RST;
    end else begin
      if (in_ready) v0_r <= in_valid;
      if (rdy1) v1_r <= close;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (mv0) begin
        if (last0_r) begin
          peak_r <= PEAK_MIN;
          any_r  <= 1'b0;
        end else begin
          peak_r <= peak_upd;
          any_r  <= any_upd;
        end
      end
      if (push) begin
        u_r       <= u_nxt;
        hist_r[0] <= peak_off;
        for (int i = 1; i < AVG_DEPTH; i++) hist_r[i] <= hist_r[i-1];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready) begin
      bin0_r  <= in_bin;
      bv0_r   <= in_bin_valid;
      last0_r <= in_last;
    end
    if (rdy1) begin
      empty1_r <= !any_upd;
      u1_r     <= u_nxt;
    end
    if (rdy2) begin
      empty2_r <= empty1_r;
      prod2_r  <= P_W'(u1_r) * P_W'(RECIP);
    end
    if (rdy3) db3_r <= db_c;
  end

  assign out_valid = v3_r;
  assign out_db    = db3_r;

  // checks
  `SHM_ASSERT_NOW(a_peak_idle, !any_r, peak_r == PEAK_MIN, "frame peak not at floor with no bin")
  `SHM_ASSERT_NOW(a_db_floor, v3_r, db3_r >= DB_FLOOR, "average dB below floor")

endmodule

// ===== rtl/shm_hold.sv =====
// dB to meter level mapping and peak-hold with timed decay
`include "signal_meter_peak_hold_unit_assert.svh"

module shm_hold (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  shm_pkg::db_t      in_db,
  input  shm_pkg::shm_cfg_t cfg,
  output logic              out_valid,
  input  logic              out_ready,
  output shm_pkg::shm_lvl_t out_lvl
);
  import shm_pkg::*;

  logic             v4_r, v5_r;
  logic [NUM_W-1:0] n4_r;
  shm_lvl_t         lvl5_r;
  level_t           held_r;
  logic [HOLD_W-1:0] cnt_r;

  logic              rdy4, rdy5, mv4, dec_go, follow;
  logic signed [31:0] db_ext, n_c;
  logic [30:0]       rnd;
  logic [14:0]       q;
  level_t            now_c, base, held_nxt;
  logic [HOLD_W-1:0] cnt_nxt;

  // stall chain
  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign mv4      = v4_r && rdy5;
  assign in_ready = rdy4;

  // linear map in Q.16, never negative above the dB floor
  assign db_ext = 32'(in_db);
  assign n_c    = db_ext * LVL_GAIN + LVL_OFS;

  // round to Q.8 and saturate at full scale
  assign rnd   = {1'b0, n4_r} + 31'd32768;
  assign q     = rnd[30:16];
  assign now_c = (q > {3'b000, LEVEL_MAX}) ? LEVEL_MAX : q[LEVEL_W-1:0];

  // decay once the hold has run out, rises follow at once
  assign dec_go = cnt_r >= cfg.hold_frames;
  assign base   = !dec_go ? held_r :
                  ((held_r > LEVEL_W'(cfg.decay_step)) ?
                   held_r - LEVEL_W'(cfg.decay_step) : '0);
  assign follow   = base <= now_c;
  assign held_nxt = follow ? now_c : base;
  assign cnt_nxt  = follow ? '0 : ((&cnt_r) ? cnt_r : cnt_r + 1'b1);

  // control and hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      held_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (rdy4) v4_r <= in_valid;
      if (rdy5) v5_r <= v4_r;
      if (mv4) begin
        held_r <= held_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy4) n4_r <= n_c[31] ? '0 : n_c[NUM_W-1:0];
    if (rdy5) begin
      lvl5_r.now  <= now_c;
      lvl5_r.held <= held_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_lvl   = lvl5_r;

  // checks
  `SHM_ASSERT_NOW(a_held_moves, $past(rst_n) && !$stable(held_r), $past(mv4), "held level changed without a frame")
  `SHM_ASSERT_NEXT(a_held_over_now, mv4, v5_r && (lvl5_r.held >= lvl5_r.now), "held level below instant level")

endmodule

// ===== rtl/shm_out.sv =====
// held level to integer dB, S-unit code and over-S9 flag, result register
`include "signal_meter_peak_hold_unit_assert.svh"

module shm_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  shm_pkg::shm_lvl_t in_lvl,
  output logic              out_valid,
  input  logic              out_ready,
  output shm_pkg::shm_res_t out_res
);
  import shm_pkg::*;

  logic        v6_r, v7_r;
  shm_lvl_t    lvl6_r;
  logic [22:0] xp6_r;
  logic [27:0] yp6_r;
  shm_res_t    res7_r;

  logic               rdy6, rdy7;
  logic signed [24:0] x;
  logic [24:0]        mag;
  logic [HDB_W-1:0]   xsh;
  logic signed [28:0] y;
  logic [SU_W-1:0]    su_c;

  // stall chain
  assign rdy7     = !v7_r || out_ready;
  assign rdy6     = !v6_r || rdy7;
  assign in_ready = rdy6;

  // dB of held level, truncated toward zero
  assign x   = $signed({2'b00, xp6_r}) - HDB_OFS;
  assign mag = x[24] ? 25'(-x) : 25'(x);
  assign xsh = mag[24:16];

  // S-unit code, floored and saturated
  assign y    = $signed({1'b0, yp6_r}) - SU_OFS;
  assign su_c = y[28] ? '0 : ((y[28:24] > {1'b0, SU_MAX}) ? SU_MAX : y[27:24]);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (rdy6) v6_r <= in_valid;
      if (rdy7) v7_r <= v6_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy6) begin
      lvl6_r <= in_lvl;
      xp6_r  <= 23'(in_lvl.held) * HDB_GAIN;
      yp6_r  <= 28'(in_lvl.held) * SU_GAIN;
    end
    if (rdy7) begin
      res7_r.level_now  <= lvl6_r.now;
      res7_r.level_held <= lvl6_r.held;
      res7_r.held_db    <= x[24] ? $signed(HDB_W'(-xsh)) : $signed(xsh);
      res7_r.s_unit     <= su_c;
      res7_r.over_s9    <= lvl6_r.held > LEVEL_S9;
    end
  end

  assign out_valid = v7_r;
  assign out_res   = res7_r;

  // checks
  `SHM_ASSERT_NOW(a_over_s_unit, v7_r && res7_r.over_s9, res7_r.s_unit >= 4'd8, "over-S9 with low S-unit code")

endmodule

// ===== rtl/signal_meter_peak_hold_unit.sv =====
// top level of the peak-hold signal level meter
//
//  channel | direction | handshake            | contents
//  in_     | slave     | in_tvalid/in_tready  | tdata bin_db, tuser bin_valid, tlast last_bin
//  out_    | master    | out_tvalid/out_tready| tdata one result per closed frame
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data register write
//
// one bin transaction is taken every cycle while in_tready is high; the per-bin work is a
// compare in the input stage, and a frame result passes each stage below on its way to out_
// the eight stages are input, sum, reciprocal multiply, clamp, level map, hold, dB/S map, result
// rst_n is synchronous and active low; it restores the register defaults and clears the valid, frame and hold state
// only closing bins travel past the input stage, so a stalled result holds back bins of
// a later frame only once seven frame results wait and another closing bin arrives
module signal_meter_peak_hold_unit #(
  parameter int AVG_DEPTH = shm_pkg::AVG_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // [12:0] bin_db
  input  logic                            in_tuser,   // [0] bin_valid
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [39:0]                     out_tdata,  // [11:0] level_now, [23:12] level_held,
                                                      // [32:24] held_db, [36:33] s_unit,
                                                      // [37] over_s9
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [shm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [shm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import shm_pkg::*;

  shm_cfg_t cfg_r;
  logic     avg_valid, avg_ready, lvl_valid, lvl_ready;
  db_t      avg_db;
  shm_lvl_t lvl;
  shm_res_t res;

  // configuration writes, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_frames <= HOLD_RST;
      cfg_r.decay_step  <= DECAY_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HOLD_FRAMES: cfg_r.hold_frames <= cfg_data[HOLD_W-1:0];
        REG_DECAY_STEP:  cfg_r.decay_step  <= cfg_data[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  // frame peak and average
  shm_avg #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_avg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_bin       (in_tdata[BIN_W-1:0]),
    .in_bin_valid (in_tuser),
    .in_last      (in_tlast),
    .out_valid    (avg_valid),
    .out_ready    (avg_ready),
    .out_db       (avg_db)
  );

  // level map and peak hold
  shm_hold u_hold (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (avg_valid),
    .in_ready  (avg_ready),
    .in_db     (avg_db),
    .cfg       (cfg_r),
    .out_valid (lvl_valid),
    .out_ready (lvl_ready),
    .out_lvl   (lvl)
  );

  // readouts and result register
  shm_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lvl_valid),
    .in_ready  (lvl_ready),
    .in_lvl    (lvl),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {2'b00, res};

endmodule
